>>> sv/rsa_pkg.sv
// Package for the RPN stack ALU: sizes, codes, word types and sequencer states.
package rsa_pkg;

  // Stack and datapath sizes
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ITER_W      = $clog2(DATA_W);

  // Function codes of an input word
  typedef enum logic [2:0] {
    FN_PUSH = 3'd0,
    FN_ADD  = 3'd1,
    FN_SUB  = 3'd2,
    FN_MUL  = 3'd3,
    FN_DIV  = 3'd4
  } func_t;

  // Status codes of a result word
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_UNDERFLOW = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_DIVZERO   = 2'd3
  } status_t;

  // Input word
  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] operand_value;
  } in_t;

  // Result word
  typedef struct packed {
    logic signed [31:0] top_value;
    logic signed [31:0] next_value;
    logic [4:0]         depth;
    logic [1:0]         status;
  } out_t;

  // Request to the shared arithmetic unit: result = opa <op> opb
  typedef struct packed {
    logic              start;
    func_t             op;
    logic [DATA_W-1:0] opa;
    logic [DATA_W-1:0] opb;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

  // Top-level sequencer
  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_EXEC,
    S_RESP
  } state_t;

  // Arithmetic unit sequencer
  typedef enum logic [2:0] {
    AU_IDLE,
    AU_ADDSUB,
    AU_NEG_NUM,
    AU_NEG_DEN,
    AU_ITER,
    AU_FIX,
    AU_DONE
  } alu_state_t;

endpackage

>>> sv/rpn_stack_alu.sv
// RPN stack ALU top level: command sequencer, stack store and result port.
//
// Pulse start with a word on in_data while busy is low; exactly one result
// word follows on out_data, marked by out_valid for a single cycle, and the
// receiver must take it then. A push or any error goes from decode straight
// to the result state; add, subtract, multiply and divide pass through
// execute first. busy drops the cycle after out_valid. Multiply and divide
// take longest: they go one bit per cycle through a single shared adder.
// The two upper entries live in registers and the rest in a 16-entry store
// with one write and one registered read port. Stack contents need no
// clearing after reset; only the depth and the sequencer state are reset.
module rpn_stack_alu (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  rsa_pkg::in_t  in_data,
  output logic          out_valid,
  output rsa_pkg::out_t out_data
);
  import rsa_pkg::*;

  state_t            state_r, state_nxt;
  in_t               cmd_r, cmd_nxt;
  logic [DATA_W-1:0] top_r, top_nxt;
  logic [DATA_W-1:0] next_r, next_nxt;
  logic [CNT_W-1:0]  depth_r, depth_nxt;
  status_t           status_r, status_nxt;

  // Entries below the two held in registers
  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  logic              mem_we;

  alu_req_t          req;
  alu_rsp_t          rsp;

  logic              is_op, is_div, underflow, div_zero, full, op_go;

  // Command decode
  assign is_div    = (cmd_r.func == FN_DIV);
  assign is_op     = (cmd_r.func == FN_ADD) || (cmd_r.func == FN_SUB) ||
                     (cmd_r.func == FN_MUL) || is_div;
  assign underflow = is_op && (depth_r < CNT_W'(2));
  assign div_zero  = is_div && !underflow && (top_r == '0);
  assign full      = !is_op && (depth_r == CNT_W'(STACK_DEPTH));
  assign op_go     = is_op && !underflow && !div_zero;

  assign wr_addr = IDX_W'(depth_r - CNT_W'(2));
  assign rd_addr = IDX_W'(depth_r - CNT_W'(3));

  rsa_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (start) state_nxt = S_DECODE;
      S_DECODE: state_nxt = op_go ? S_EXEC : S_RESP;
      S_EXEC:   if (rsp.done) state_nxt = S_RESP;
      S_RESP:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy      = (state_r != S_IDLE);
    out_valid = (state_r == S_RESP);
    req.start = (state_r == S_DECODE) && op_go;
    req.op    = func_t'(cmd_r.func);
    req.opa   = next_r;
    req.opb   = top_r;
    mem_we    = (state_r == S_DECODE) && !is_op && !full && (depth_r >= CNT_W'(2));

    out_data.top_value  = (depth_r >= CNT_W'(1)) ? top_r : '0;
    out_data.next_value = (depth_r >= CNT_W'(2)) ? next_r : '0;
    out_data.depth      = 5'(depth_r);
    out_data.status     = status_r;
  end

  // Stack registers
  always_comb begin
    cmd_nxt    = cmd_r;
    top_nxt    = top_r;
    next_nxt   = next_r;
    depth_nxt  = depth_r;
    status_nxt = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) cmd_nxt = in_data;
      end
      S_DECODE: begin
        if (underflow) begin
          status_nxt = STAT_UNDERFLOW;
        end else if (div_zero) begin
          status_nxt = STAT_DIVZERO;
        end else if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          status_nxt = STAT_OK;
          if (!is_op) begin
            // push: old top drops to next, old next spills to the store
            top_nxt   = cmd_r.operand_value;
            next_nxt  = top_r;
            depth_nxt = depth_r + CNT_W'(1);
          end
        end
      end
      S_EXEC: begin
        if (rsp.done) begin
          // pop two, push result; the store refills next
          top_nxt   = rsp.result;
          next_nxt  = rd_data_r;
          depth_nxt = depth_r - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      depth_r <= '0;
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    top_r    <= top_nxt;
    next_r   <= next_nxt;
    status_r <= status_nxt;
  end

  // Stack store
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= next_r;
    rd_data_r <= mem[rd_addr];
  end

  // Checks
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= CNT_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_resp_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy && !out_valid)
    else $error("result strobe not followed by idle");

  a_done_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> state_r == S_EXEC)
    else $error("arithmetic unit finished outside execute");

  a_depth_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_DECODE && state_r != S_EXEC) |=> $stable(depth_r))
    else $error("depth changed outside decode or execute");

endmodule

>>> sv/rsa_alu.sv
// Shared arithmetic unit: one 33-bit adder reused for add, subtract,
// shift-add multiply and restoring divide with sign correction.
module rsa_alu (
  input  logic            clk,
  input  logic            rst_n,
  input  rsa_pkg::alu_req_t req,
  output rsa_pkg::alu_rsp_t rsp
);
  import rsa_pkg::*;

  alu_state_t        state_r, state_nxt;
  func_t             op_r, op_nxt;
  logic [DATA_W-1:0] x_r, x_nxt;      // multiplicand / numerator then quotient
  logic [DATA_W-1:0] y_r, y_nxt;      // multiplier / divisor
  logic [DATA_W-1:0] acc_r, acc_nxt;  // product / remainder / result
  logic [ITER_W-1:0] cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;

  // Shared adder
  logic [DATA_W:0]   add_a, add_b, sum;
  logic              add_sub;
  logic [DATA_W:0]   shifted;
  logic              last_iter;

  assign shifted   = {acc_r, x_r[DATA_W-1]};
  assign sum       = add_a + (add_b ^ {(DATA_W+1){add_sub}}) + (DATA_W+1)'(add_sub);
  assign last_iter = (cnt_r == ITER_W'(DATA_W - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      AU_IDLE: begin
        if (req.start) begin
          case (req.op)
            FN_ADD, FN_SUB: state_nxt = AU_ADDSUB;
            FN_MUL:         state_nxt = AU_ITER;
            FN_DIV:         state_nxt = AU_NEG_NUM;
            default:        state_nxt = AU_DONE;
          endcase
        end
      end
      AU_ADDSUB:  state_nxt = AU_DONE;
      AU_NEG_NUM: state_nxt = AU_NEG_DEN;
      AU_NEG_DEN: state_nxt = AU_ITER;
      AU_ITER: begin
        if (last_iter) begin
          state_nxt = (op_r == FN_DIV) ? AU_FIX : AU_DONE;
        end
      end
      AU_FIX:  state_nxt = AU_DONE;
      AU_DONE: state_nxt = AU_IDLE;
      default: state_nxt = AU_IDLE;
    endcase
  end

  // Outputs: adder operand selection and response
  always_comb begin
    add_a   = {1'b0, x_r};
    add_b   = {1'b0, y_r};
    add_sub = 1'b0;
    unique case (state_r)
      AU_ADDSUB: add_sub = (op_r == FN_SUB);
      AU_NEG_NUM, AU_FIX: begin
        add_a   = '0;
        add_b   = {1'b0, x_r};
        add_sub = 1'b1;
      end
      AU_NEG_DEN: begin
        add_a   = '0;
        add_sub = 1'b1;
      end
      AU_ITER: begin
        if (op_r == FN_DIV) begin
          add_a   = shifted;
          add_sub = 1'b1;
        end else begin
          add_a = {1'b0, acc_r};
          add_b = {1'b0, x_r};
        end
      end
      default: ;
    endcase
    rsp.done   = (state_r == AU_DONE);
    rsp.result = acc_r;
  end

  // Datapath
  always_comb begin
    op_nxt  = op_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    neg_nxt = neg_r;
    unique case (state_r)
      AU_IDLE: begin
        if (req.start) begin
          op_nxt  = req.op;
          x_nxt   = req.opa;
          y_nxt   = req.opb;
          acc_nxt = '0;
          cnt_nxt = '0;
          neg_nxt = req.opa[DATA_W-1] ^ req.opb[DATA_W-1];
        end
      end
      AU_ADDSUB: acc_nxt = sum[DATA_W-1:0];
      AU_NEG_NUM: begin
        if (x_r[DATA_W-1]) x_nxt = sum[DATA_W-1:0];
      end
      AU_NEG_DEN: begin
        if (y_r[DATA_W-1]) y_nxt = sum[DATA_W-1:0];
      end
      AU_ITER: begin
        cnt_nxt = cnt_r + ITER_W'(1);
        if (op_r == FN_DIV) begin
          // restoring step: keep the difference when it did not borrow
          acc_nxt = sum[DATA_W] ? shifted[DATA_W-1:0] : sum[DATA_W-1:0];
          x_nxt   = {x_r[DATA_W-2:0], ~sum[DATA_W]};
        end else begin
          if (y_r[0]) acc_nxt = sum[DATA_W-1:0];
          x_nxt = {x_r[DATA_W-2:0], 1'b0};
          y_nxt = {1'b0, y_r[DATA_W-1:1]};
        end
      end
      AU_FIX: acc_nxt = neg_r ? sum[DATA_W-1:0] : x_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AU_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

endmodule

>>> verif/rpn_stack_alu_test.sv
// Self-checking testbench for rpn_stack_alu: queued command words, bursty driver, result check.
`timescale 1ns / 1ps

module rpn_stack_alu_test;
  import rsa_pkg::*;

  // Spare func codes that the block treats as a push
  localparam logic [2:0] FN_SPARE_LO = 3'd5;
  localparam logic [2:0] FN_SPARE_HI = 3'd7;

  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

  localparam int RANDOM_WORDS = 800;
  localparam int CHUNK_WORDS  = 40;
  localparam int TAIL_CYCLES  = 60;

  // One entry of the stimulus queue: a command word, or a hold until drained
  typedef struct {
    bit  hold;
    in_t word;
  } pend_t;

  logic clk;
  logic rst_n;
  logic start = 1'b0;
  in_t  in_data = '0;
  logic busy;
  logic out_valid;
  out_t out_data;

  pend_t pending_q[$];
  out_t  expected_q[$];

  int accepted_cnt = 0;
  int results_seen = 0;
  int err_cnt = 0;
  int gap_left = 0;
  int burst_left = 0;

  // Shadow stack of the calculator
  logic [31:0] calc_stack [STACK_DEPTH];
  int unsigned calc_depth = 0;

  rpn_stack_alu dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one command word to the shadow stack and return the result word it gives
  function automatic out_t calc_step(in_t w);
    out_t        r;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] v;
    longint      q;
    status_t     st;
    st = STAT_OK;
    v  = '0;
    case (w.func)
      FN_ADD, FN_SUB, FN_MUL, FN_DIV: begin
        if (calc_depth < 2) begin
          st = STAT_UNDERFLOW;
        end else begin
          a = calc_stack[calc_depth - 1];
          b = calc_stack[calc_depth - 2];
          case (w.func)
            FN_ADD: v = b + a;
            FN_SUB: v = b - a;
            FN_MUL: v = b * a;
            default: begin
              // 64-bit quotient, so most negative over minus one wraps cleanly
              if (a == '0) begin
                st = STAT_DIVZERO;
              end else begin
                q = longint'($signed(b)) / longint'($signed(a));
                v = q[31:0];
              end
            end
          endcase
          if (st == STAT_OK) begin
            calc_stack[calc_depth - 2] = v;
            calc_depth--;
          end
        end
      end
      // push, spare codes included
      default: begin
        if (calc_depth >= STACK_DEPTH) begin
          st = STAT_FULL;
        end else begin
          calc_stack[calc_depth] = w.operand_value;
          calc_depth++;
        end
      end
    endcase
    r.top_value  = (calc_depth >= 1) ? calc_stack[calc_depth - 1] : '0;
    r.next_value = (calc_depth >= 2) ? calc_stack[calc_depth - 2] : '0;
    r.depth      = 5'(calc_depth);
    r.status     = st;
    return r;
  endfunction

  task automatic queue_word(logic [2:0] f, logic signed [31:0] v);
    pend_t p;
    p.hold               = 1'b0;
    p.word.func          = f;
    p.word.operand_value = v;
    pending_q.push_back(p);
  endtask

  task automatic queue_hold();
    pend_t p;
    p.hold = 1'b1;
    p.word = '0;
    pending_q.push_back(p);
  endtask

  // Driver: bursts of words from the queue, random gaps, holds until drained
  always @(posedge clk) begin : drive
    logic fire;
    fire = start && !busy;
    if (!rst_n) begin
      start   <= 1'b0;
      in_data <= '0;
    end else begin
      if (fire) begin
        expected_q.push_back(calc_step(in_data));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (fire || !start) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (pending_q.size() == 0) begin
          start <= 1'b0;
        end else if (pending_q[0].hold) begin
          if (!fire && accepted_cnt == results_seen) void'(pending_q.pop_front());
          start <= 1'b0;
        end else begin
          in_data <= pending_q[0].word;
          start   <= 1'b1;
          void'(pending_q.pop_front());
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            // half the bursts run straight on into the next
            gap_left   <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 45);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Monitor: every result word against the oldest expectation
  always @(posedge clk) begin : watch
    out_t want;
    if (rst_n && out_valid) begin
      results_seen <= results_seen + 1;
      if (expected_q.size() == 0) begin
        $error("result word with none expected: top %0d depth %0d status %0d",
               out_data.top_value, out_data.depth, out_data.status);
        err_cnt++;
      end else begin
        want = expected_q.pop_front();
        if (out_data.top_value !== want.top_value) begin
          $error("top_value: expected %0d, got %0d", want.top_value, out_data.top_value);
          err_cnt++;
        end
        if (out_data.next_value !== want.next_value) begin
          $error("next_value: expected %0d, got %0d", want.next_value, out_data.next_value);
          err_cnt++;
        end
        if (out_data.depth !== want.depth) begin
          $error("depth: expected %0d, got %0d", want.depth, out_data.depth);
          err_cnt++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          err_cnt++;
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int               push_pct;
    logic [2:0]       f;
    logic signed [31:0] v;
    rst_n = 1'b0;

    // Directed: underflow, wrap, overflowing quotient, zero divisor, spare codes
    queue_word(FN_ADD, INT_MAX);
    queue_word(FN_PUSH, INT_MAX);
    queue_word(FN_DIV, 32'sd0);
    queue_word(FN_PUSH, 32'sd1);
    queue_word(FN_ADD, 32'sd0);
    queue_word(FN_PUSH, -32'sd1);
    queue_word(FN_DIV, INT_MIN);
    queue_word(FN_PUSH, 32'sd0);
    queue_word(FN_DIV, -32'sd1);
    queue_word(FN_SUB, 32'sd0);
    queue_word(FN_PUSH, INT_MIN);
    queue_word(FN_MUL, 32'sd0);
    queue_word(FN_SPARE_LO, -32'sd7);
    queue_word(FN_SPARE_HI, 32'sd2);
    queue_word(FN_DIV, 32'sd0);
    queue_word(FN_SPARE_LO + 3'd1, 32'sd6);
    queue_word(FN_MUL, 32'sd0);
    queue_word(FN_ADD, 32'sd0);
    queue_word(FN_PUSH, INT_MAX);
    queue_word(FN_PUSH, INT_MAX);
    queue_word(FN_MUL, INT_MAX);
    queue_word(FN_SUB, INT_MIN);
    queue_hold();

    // Random: chunks biased towards pushing or popping so the stack fills and empties
    push_pct = 50;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % CHUNK_WORDS == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 30;
          1:       push_pct = 50;
          default: push_pct = 70;
        endcase
        if ($urandom_range(0, 3) == 0) queue_hold();
      end
      case ($urandom_range(0, 9))
        0:       v = INT_MIN;
        1:       v = INT_MAX;
        2:       v = -32'sd1;
        3:       v = 32'sd0;
        4, 5:    v = $signed(32'($urandom_range(0, 16))) - 32'sd8;
        default: v = $urandom;
      endcase
      if ($urandom_range(1, 100) <= push_pct) begin
        f = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI))
                                        : FN_PUSH;
      end else begin
        case ($urandom_range(0, 3))
          0:       f = FN_ADD;
          1:       f = FN_SUB;
          2:       f = FN_MUL;
          default: f = FN_DIV;
        endcase
      end
      queue_word(f, v);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // settled values only, away from the active edge
    do @(negedge clk);
    while (pending_q.size() != 0 || start || accepted_cnt != results_seen);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_q.size() != 0) begin
      $error("%0d result words never arrived", expected_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("rpn_stack_alu_test: done, clean");
    end else begin
      $display("rpn_stack_alu_test: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("rpn_stack_alu_test: done, errors");
    $finish;
  end

endmodule
